@@ design/rle_row_encoder_top_assert.svh @@
// Assertion macros used by the encoder's command queue module.
`ifndef RLE_ROW_ENCODER_TOP_ASSERT_SVH
`define RLE_ROW_ENCODER_TOP_ASSERT_SVH
// Plain property, clocked on clk, off during rst.
`define RLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Next-cycle implication.
`define RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`endif

@@ design/rle_enc_pkg.sv @@
package rle_enc_pkg;

  localparam int unsigned PACKET_MAX_DEF = 256;
  localparam int unsigned PLANES_DEF     = 3;
  localparam int unsigned CHUNK_BYTES    = 8;
  localparam int unsigned CQ_DEPTH       = 8;
  localparam int unsigned PUSH_MAX       = 4;
  localparam int unsigned PUSH_W         = 3;
  localparam int unsigned LEN_W          = 9;

  localparam logic [7:0]  OP_SKIP_LINES  = 8'd1;
  localparam logic [7:0]  OP_SET_CHANNEL = 8'd2;
  localparam logic [7:0]  OP_RAW         = 8'd5;
  localparam logic [7:0]  OP_RUN         = 8'd6;
  localparam logic [8:0]  NO_PIXEL       = 9'h100;
  localparam logic [15:0] LINE_WIDTH_RST = 16'd256;

  typedef enum logic [1:0] {CMD_HDR, CMD_RAW, CMD_RUN, CMD_SKIP} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [LEN_W-1:0] len;
    logic [7:0]       value;
    logic             bank;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } raw_done_t;

  typedef struct packed {
    logic [7:0] pixel;
  } pix_t;

  typedef struct packed {
    logic [15:0] line_width;
  } cfg_t;

  typedef struct packed {
    logic [8*CHUNK_BYTES-1:0] out_bytes;
    logic [3:0]               out_count;
    logic                     last_of_run;
  } res_t;

endpackage

@@ design/rle_enc_if.sv @@
interface rle_enc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/rle_enc_front.sv @@
module rle_enc_front #(
  parameter int unsigned PACKET_MAX = rle_enc_pkg::PACKET_MAX_DEF,
  parameter int unsigned PLANES     = rle_enc_pkg::PLANES_DEF,
  localparam int unsigned AW        = $clog2(PACKET_MAX)
) (
  input  logic                                clk,
  input  logic                                rst,
  rle_enc_if.sink                             pix,
  rle_enc_if.sink                             cfg,
  input  logic                                q_room,
  output logic [rle_enc_pkg::PUSH_W-1:0]      push_n,
  output rle_enc_pkg::cmd_t                   push_cmd [rle_enc_pkg::PUSH_MAX],
  input  rle_enc_pkg::raw_done_t              done,
  output logic                                mem_we,
  output logic [AW:0]                         mem_waddr,
  output logic [7:0]                          mem_wdata
);
  import rle_enc_pkg::*;

  localparam logic [LEN_W-1:0] PKT_LEN    = LEN_W'(PACKET_MAX);
  localparam logic [1:0]       PLANE_LAST = 2'(PLANES - 1);

  logic [15:0]      line_width;
  logic [LEN_W-1:0] pend_len, pend_len_next;
  logic             run_mode, run_mode_next;
  logic             pair_seen, pair_seen_next;
  logic [8:0]       prev_pixel, prev_pixel_next;
  logic [7:0]       run_value, run_value_next;
  logic [15:0]      column, column_next;
  logic [1:0]       plane, plane_next;
  logic             bank, bank_next;
  logic [1:0]       busy, busy_next;

  cmd_t             cand [PUSH_MAX];
  logic [PUSH_MAX-1:0] cen;
  cmd_t             slot [PUSH_MAX];
  logic [PUSH_W-1:0] n_cmds;
  logic             we;
  logic [AW-1:0]    widx;
  logic             wb_pre;
  logic             accept;

  function automatic cmd_t mk_cmd(cmd_kind_t k, logic [LEN_W-1:0] l, logic [7:0] v,
                                  logic b);
    cmd_t c;
    c.kind  = k;
    c.len   = l;
    c.value = v;
    c.bank  = b;
    c.last  = 1'b0;
    return c;
  endfunction

  // a full raw packet flushes before the pixel lands, so the write goes to the other bank
  assign wb_pre    = bank ^ ((column != 16'd0) && (pend_len >= PKT_LEN) && !run_mode);
  assign pix.ready = q_room && !busy[wb_pre];
  assign accept    = pix.valid && pix.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    logic [7:0]       px;
    logic [LEN_W-1:0] len;
    logic             rm;
    logic             ps;
    logic [8:0]       pv;
    logic [7:0]       rv;
    logic             bk;
    logic [1:0]       pl;
    logic [15:0]      col_n;
    logic [1:0]       lastsel;
    px    = pix.data.pixel;
    len   = pend_len;
    rm    = run_mode;
    ps    = pair_seen;
    pv    = prev_pixel;
    rv    = run_value;
    bk    = bank;
    pl    = plane;
    col_n = column + 16'd1;
    cen   = '0;
    we    = 1'b0;
    widx  = '0;
    for (int i = 0; i < PUSH_MAX; i++) begin
      cand[i] = '0;
    end

    if (column == 16'd0) begin
      cen[0]  = 1'b1;
      cand[0] = mk_cmd(CMD_HDR, '0, {6'd0, plane}, 1'b0);
      we   = 1'b1;
      widx = '0;
      len  = 9'd1;
      rm   = 1'b0;
      ps   = 1'b0;
    end else begin
      if (len >= PKT_LEN) begin
        cen[0]  = 1'b1;
        cand[0] = rm ? mk_cmd(CMD_RUN, len, rv, bk) : mk_cmd(CMD_RAW, len, 8'd0, bk);
        if (!rm) begin
          bk = ~bk;
        end
        len = '0;
        rm  = 1'b0;
        ps  = 1'b0;
        pv  = NO_PIXEL;
      end
      if ({1'b0, px} == pv) begin
        if (rm) begin
          len = len + 9'd1;
        end else if (ps) begin
          // third equal pixel: raw part before the pair goes out, run starts
          if (len != 9'd2) begin
            cen[1]  = 1'b1;
            cand[1] = mk_cmd(CMD_RAW, len - 9'd2, 8'd0, bk);
            bk      = ~bk;
          end
          rm  = 1'b1;
          rv  = px;
          len = 9'd3;
          ps  = 1'b0;
        end else begin
          ps   = 1'b1;
          we   = 1'b1;
          widx = len[AW-1:0];
          len  = len + 9'd1;
        end
      end else if (rm) begin
        cen[1]  = 1'b1;
        cand[1] = mk_cmd(CMD_RUN, len, rv, bk);
        we   = 1'b1;
        widx = '0;
        len  = 9'd1;
        rm   = 1'b0;
        ps   = 1'b0;
      end else begin
        ps   = 1'b0;
        we   = 1'b1;
        widx = len[AW-1:0];
        len  = len + 9'd1;
      end
    end
    pv = {1'b0, px};

    if (col_n == line_width) begin
      if (len != '0) begin
        cen[2]  = 1'b1;
        cand[2] = rm ? mk_cmd(CMD_RUN, len, rv, bk) : mk_cmd(CMD_RAW, len, 8'd0, bk);
        if (!rm) begin
          bk = ~bk;
        end
      end
      len   = '0;
      rm    = 1'b0;
      ps    = 1'b0;
      pv    = NO_PIXEL;
      col_n = 16'd0;
      if (pl == PLANE_LAST) begin
        pl      = 2'd0;
        cen[3]  = 1'b1;
        cand[3] = mk_cmd(CMD_SKIP, '0, 8'd0, 1'b0);
      end else begin
        pl = pl + 2'd1;
      end
    end

    pend_len_next   = len;
    run_mode_next   = rm;
    pair_seen_next  = ps;
    prev_pixel_next = pv;
    run_value_next  = rv;
    bank_next       = bk;
    plane_next      = pl;
    column_next     = col_n;

    // pack enabled commands to the front, flag the final one of this pixel
    lastsel = '0;
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (cen[i]) begin
        lastsel = 2'(i);
      end
    end
    n_cmds = '0;
    for (int i = 0; i < PUSH_MAX; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (cen[i]) begin
        slot[n_cmds[1:0]]      = cand[i];
        slot[n_cmds[1:0]].last = (lastsel == 2'(i));
        n_cmds                 = n_cmds + 3'd1;
      end
    end

    busy_next = busy;
    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (accept) begin
      for (int i = 0; i < PUSH_MAX; i++) begin
        if (cen[i] && (cand[i].kind == CMD_RAW)) begin
          busy_next[cand[i].bank] = 1'b1;
        end
      end
    end
  end

  assign push_n    = accept ? n_cmds : '0;
  assign push_cmd  = slot;
  assign mem_we    = accept && we;
  assign mem_waddr = {wb_pre, widx};
  assign mem_wdata = pix.data.pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      pend_len   <= '0;
      run_mode   <= 1'b0;
      pair_seen  <= 1'b0;
      prev_pixel <= NO_PIXEL;
      run_value  <= 8'd0;
      column     <= 16'd0;
      plane      <= 2'd0;
      bank       <= 1'b0;
      busy       <= 2'b00;
    end else begin
      busy <= busy_next;
      if (cfg.valid) begin
        line_width <= cfg.data.line_width;
      end
      if (accept) begin
        pend_len   <= pend_len_next;
        run_mode   <= run_mode_next;
        pair_seen  <= pair_seen_next;
        prev_pixel <= prev_pixel_next;
        run_value  <= run_value_next;
        column     <= column_next;
        plane      <= plane_next;
        bank       <= bank_next;
      end
    end
  end

endmodule

@@ design/rle_enc_cmdq.sv @@
`include "rle_row_encoder_top_assert.svh"

module rle_enc_cmdq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rle_enc_pkg::PUSH_W-1:0] push_n,
  input  rle_enc_pkg::cmd_t              push_cmd [rle_enc_pkg::PUSH_MAX],
  output logic                           room,
  output rle_enc_pkg::cmd_t              head,
  output logic                           head_valid,
  input  logic                           pop
);
  import rle_enc_pkg::*;

  localparam int unsigned PW = $clog2(CQ_DEPTH);
  localparam int unsigned CW = $clog2(CQ_DEPTH + 1);

  cmd_t          q [CQ_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;

  assign room       = (cnt <= CW'(CQ_DEPTH - PUSH_MAX));
  assign head_valid = (cnt != '0);
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (PUSH_W'(i) < push_n) begin
        q[PW'(wptr + PW'(i))] <= push_cmd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= PW'(wptr + PW'(push_n));
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      cnt <= CW'(cnt + CW'(push_n) - CW'(pop));
    end
  end

  `RLE_ASSERT(a_q_no_overflow, (push_n == '0) || (cnt <= CW'(CQ_DEPTH - PUSH_MAX)), "cmd queue overflow")
  `RLE_ASSERT(a_q_no_underflow, !pop || (cnt != '0), "cmd queue pop while empty")
  `RLE_ASSERT_NEXT(a_q_cnt_hold, (push_n == '0) && !pop, $stable(cnt), "cmd queue count moved")

endmodule

@@ design/rle_enc_back.sv @@
module rle_enc_back #(
  parameter int unsigned PACKET_MAX = rle_enc_pkg::PACKET_MAX_DEF,
  localparam int unsigned AW        = $clog2(PACKET_MAX)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rle_enc_pkg::cmd_t      head,
  input  logic                   head_valid,
  output logic                   pop,
  output rle_enc_pkg::raw_done_t done,
  input  logic                   mem_we,
  input  logic [AW:0]            mem_waddr,
  input  logic [7:0]             mem_wdata,
  rle_enc_if.source              res
);
  import rle_enc_pkg::*;

  localparam int unsigned CBW = $clog2(CHUNK_BYTES);

  // two banks of pending raw pixels
  logic [7:0]       mem [2**(AW+1)];
  logic [7:0]       mem_rd;

  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] total_m1;
  logic [LEN_W-1:0] didx;
  logic             last_b;
  logic [7:0]       lit;
  logic             is_mem;
  logic             gen_fire;
  logic [AW:0]      raddr;

  logic             s1_valid;
  logic             s1_mem;
  logic [7:0]       s1_lit;
  logic             s1_final;
  logic             s1_free;
  logic             accept_byte;

  logic [8*CHUNK_BYTES-1:0] chunk;
  logic [8*CHUNK_BYTES-1:0] chunk_ins;
  logic [CBW-1:0]           ccnt;
  logic [3:0]               newcnt;
  logic                     flush;
  logic [7:0]               b;
  logic                     out_free;
  logic                     out_valid;
  res_t                     out_reg;

  always_comb begin
    logic [7:0] lm1;
    lm1    = 8'(head.len - 9'd1);
    didx   = pos - 9'd2;
    lit    = 8'd0;
    is_mem = 1'b0;
    unique case (head.kind)
      CMD_HDR: begin
        total_m1 = 9'd1;
        lit      = (pos == '0) ? OP_SET_CHANNEL : head.value;
      end
      CMD_SKIP: begin
        total_m1 = 9'd1;
        lit      = (pos == '0) ? OP_SKIP_LINES : 8'd1;
      end
      CMD_RUN: begin
        total_m1 = 9'd3;
        case (pos)
          9'd0:    lit = OP_RUN;
          9'd1:    lit = lm1;
          9'd2:    lit = head.value;
          default: lit = 8'd0;
        endcase
      end
      CMD_RAW: begin
        // opcode, count-1, data, pad byte on odd count
        total_m1 = head.len + 9'd1 + {8'd0, head.len[0]};
        if (pos == '0) begin
          lit = OP_RAW;
        end else if (pos == 9'd1) begin
          lit = lm1;
        end else if (didx < head.len) begin
          is_mem = 1'b1;
        end
      end
      default: begin
        total_m1 = 9'd1;
      end
    endcase
  end

  assign last_b      = (pos == total_m1);
  assign raddr       = {head.bank, didx[AW-1:0]};
  assign out_free    = !out_valid || res.ready;
  assign accept_byte = s1_valid && out_free;
  assign s1_free     = !s1_valid || accept_byte;
  assign gen_fire    = head_valid && s1_free;
  assign pop         = gen_fire && last_b;
  assign done.valid  = pop && (head.kind == CMD_RAW);
  assign done.bank   = head.bank;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (gen_fire) begin
      mem_rd <= mem[raddr];
    end
  end

  always_comb begin
    b         = s1_mem ? mem_rd : s1_lit;
    newcnt    = {1'b0, ccnt} + 4'd1;
    flush     = s1_final || (newcnt == 4'(CHUNK_BYTES));
    chunk_ins = chunk;
    chunk_ins[{ccnt, 3'b000} +: 8] = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      s1_valid  <= 1'b0;
      ccnt      <= '0;
      chunk     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (gen_fire) begin
        pos <= last_b ? '0 : pos + 9'd1;
      end
      if (s1_free) begin
        s1_valid <= gen_fire;
      end
      if (accept_byte) begin
        if (flush) begin
          chunk <= '0;
          ccnt  <= '0;
        end else begin
          chunk <= chunk_ins;
          ccnt  <= ccnt + CBW'(1);
        end
      end
      if (accept_byte && flush) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_mem   <= is_mem;
      s1_lit   <= lit;
      s1_final <= head.last && last_b;
    end
    if (accept_byte && flush) begin
      out_reg.out_bytes   <= chunk_ins;
      out_reg.out_count   <= newcnt;
      out_reg.last_of_run <= s1_final;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_reg;

endmodule

@@ design/rle_row_encoder_top.sv @@
// Throughput: one pixel per cycle while the command queue has room and the
// raw buffer bank being filled is not still being read; output rate is one
// byte per cycle, packed into chunks of up to 8 bytes, unless res stalls.
// Reset: rst synchronous, active high; clears plane/row state, line_width=256.
module rle_row_encoder_top #(
  parameter int unsigned PACKET_MAX = rle_enc_pkg::PACKET_MAX_DEF,
  parameter int unsigned PLANES     = rle_enc_pkg::PLANES_DEF
) (
  input logic       clk,
  input logic       rst,
  rle_enc_if.sink   pix,
  rle_enc_if.sink   cfg,
  rle_enc_if.source res
);
  import rle_enc_pkg::*;

  localparam int unsigned AW = $clog2(PACKET_MAX);

  logic              q_room;
  logic [PUSH_W-1:0] push_n;
  cmd_t              push_cmd [PUSH_MAX];
  raw_done_t         done;
  logic              mem_we;
  logic [AW:0]       mem_waddr;
  logic [7:0]        mem_wdata;
  cmd_t              head;
  logic              head_valid;
  logic              pop;

  rle_enc_front #(
    .PACKET_MAX(PACKET_MAX),
    .PLANES    (PLANES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .cfg      (cfg),
    .q_room   (q_room),
    .push_n   (push_n),
    .push_cmd (push_cmd),
    .done     (done),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  rle_enc_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_cmd  (push_cmd),
    .room      (q_room),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  rle_enc_back #(
    .PACKET_MAX(PACKET_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .done      (done),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .res       (res)
  );

endmodule
